// ===== src/point_light_diffuse_specular_shader_unit_assert.svh =====
// Assertion macros for the point light shader unit checker.
// Needs clk and rst_n in the scope where the macros are used.
`ifndef POINT_LIGHT_DIFFUSE_SPECULAR_SHADER_UNIT_ASSERT_SVH
`define POINT_LIGHT_DIFFUSE_SPECULAR_SHADER_UNIT_ASSERT_SVH

// same-cycle implication, off during reset
`define PLDS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("plds: same-cycle check failed");

// next-cycle implication, off during reset
`define PLDS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("plds: next-cycle check failed");

// next-cycle implication that also runs through reset
`define PLDS_ASSERT_RST(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("plds: reset check failed");

`endif

// ===== src/plds_pkg.sv =====
// Shared types and constants of the point light shader unit.
// No dependencies.
package plds_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_LIGHT_X  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LIGHT_Y  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LIGHT_Z  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CAMERA_X = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CAMERA_Y = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CAMERA_Z = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_RATIO    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_COLOR    = 3'd7;

  localparam logic [23:0] COLOR_RST = 24'hFFFFFF;

  // normalizer widths
  localparam int VEC_W     = 36;            // raw vector component, signed
  localparam int DIR_W     = 16;            // Q2.14 direction component
  localparam int FRAC_B    = 14;
  localparam int MAG_W     = 31;            // magnitude after prescale, <= 2^30
  localparam int SHIFT_W   = 3;
  localparam int SQ_W      = 2 * MAG_W;     // sum of squares
  localparam int NUM_W     = MAG_W + FRAC_B;
  localparam int ISQ_STEPS = SQ_W / 2 + 1;  // root bits from 2^62 down to 2^0
  localparam int DIV_STEPS = FRAC_B + 1;    // quotient is at most 2^14
  localparam int NORM_LAT  = 4 + ISQ_STEPS + DIV_STEPS + 1;

  // shading
  localparam int SHINE_EXPONENT = 32;
  localparam int ONE_SH  = 30;
  localparam logic [MAG_W-1:0] ONE_Q30 = MAG_W'(1) << ONE_SH;
  localparam int PROD_W  = 56;
  localparam int DIF_SH  = 36;
  localparam int SPEC_SH = 39;

  typedef struct packed {
    logic signed [31:0] hit_x;
    logic signed [31:0] hit_y;
    logic signed [31:0] hit_z;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic signed [15:0] incident_x;
    logic signed [15:0] incident_y;
    logic signed [15:0] incident_z;
  } in_item_t;

  typedef struct packed {
    logic [15:0] diffuse_red;
    logic [15:0] diffuse_green;
    logic [15:0] diffuse_blue;
    logic [15:0] specular_red;
    logic [15:0] specular_green;
    logic [15:0] specular_blue;
  } out_item_t;

  typedef struct packed {
    logic signed [VEC_W-1:0] x;
    logic signed [VEC_W-1:0] y;
    logic signed [VEC_W-1:0] z;
  } vec3_t;

  typedef struct packed {
    logic signed [DIR_W-1:0] x;
    logic signed [DIR_W-1:0] y;
    logic signed [DIR_W-1:0] z;
  } dir3_t;

endpackage

// ===== src/plds_norm.sv =====
// Pipelined vector normalizer: prescale, sum of squares, bit-serial root,
// restoring divide per lane. Depends on plds_pkg.
module plds_norm (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_valid,
  input  plds_pkg::vec3_t     in_vec,
  output logic                out_valid,
  output plds_pkg::dir3_t     out_dir
);
  localparam int VW = plds_pkg::VEC_W;
  localparam int MW = plds_pkg::MAG_W;
  localparam int SW = plds_pkg::SQ_W;
  localparam int RW = plds_pkg::SQ_W + 2;
  localparam int NW = plds_pkg::NUM_W;
  localparam int FB = plds_pkg::FRAC_B;
  localparam int DW = plds_pkg::DIR_W;
  localparam int IS = plds_pkg::ISQ_STEPS;
  localparam int DS = plds_pkg::DIV_STEPS;
  localparam int HW = plds_pkg::SHIFT_W;

  // stage 1: magnitudes and their maximum
  logic signed [VW-1:0] v_in [3];
  logic [VW-1:0]        m_in [3];
  logic [VW-1:0]        mx_nxt;
  logic signed [VW-1:0] n1_v_r [3];
  logic [VW-1:0]        n1_mx_r;
  logic                 n1_val_r;

  always_comb begin
    v_in[0] = in_vec.x;
    v_in[1] = in_vec.y;
    v_in[2] = in_vec.z;
    for (int i = 0; i < 3; i++) begin
      m_in[i] = v_in[i][VW-1] ? VW'(-v_in[i]) : VW'(v_in[i]);
    end
    mx_nxt = m_in[0];
    if (m_in[1] > mx_nxt) mx_nxt = m_in[1];
    if (m_in[2] > mx_nxt) mx_nxt = m_in[2];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) n1_v_r[i] <= v_in[i];
      n1_mx_r <= mx_nxt;
    end
  end

  // stage 2: floor-shift until every magnitude is at most 2^30
  logic [HW-1:0]        sh_nxt;
  logic signed [VW-1:0] a_nxt [3];
  logic [2:0][MW-1:0]   n2_m_r;
  logic [2:0]           n2_neg_r;
  logic                 n2_val_r;

  always_comb begin
    sh_nxt = '0;
    for (int k = 0; k < VW - 30; k++) begin
      if ((n1_mx_r >> (30 + k)) != '0) sh_nxt = HW'(k + 1);
    end
    for (int i = 0; i < 3; i++) a_nxt[i] = n1_v_r[i] >>> sh_nxt;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        n2_m_r[i]   <= a_nxt[i][VW-1] ? MW'(-a_nxt[i]) : MW'(a_nxt[i]);
        n2_neg_r[i] <= n1_v_r[i][VW-1];
      end
    end
  end

  // stage 3: squares
  logic [SW-1:0]      n3_sq_r [3];
  logic [2:0][MW-1:0] n3_m_r;
  logic [2:0]         n3_neg_r;
  logic               n3_val_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        n3_sq_r[i] <= SW'(n2_m_r[i]) * SW'(n2_m_r[i]);
      end
      n3_m_r   <= n2_m_r;
      n3_neg_r <= n2_neg_r;
    end
  end

  // integer square root, one result bit per stage
  logic [SW-1:0]      is_x_r   [IS+1];
  logic [RW-1:0]      is_r_r   [IS+1];
  logic [2:0][MW-1:0] is_m_r   [IS+1];
  logic [2:0]         is_neg_r [IS+1];
  logic               is_val_r [IS+1];

  always_ff @(posedge clk) begin
    if (en) begin
      is_x_r[0]   <= n3_sq_r[0] + n3_sq_r[1] + n3_sq_r[2];
      is_r_r[0]   <= '0;
      is_m_r[0]   <= n3_m_r;
      is_neg_r[0] <= n3_neg_r;
    end
  end

  for (genvar k = 0; k < IS; k++) begin : g_isq
    localparam logic [RW-1:0] BIT = RW'(1) << (SW - 2 * k);
    logic [RW-1:0] trial;
    logic          take;

    assign trial = is_r_r[k] + BIT;
    assign take  = RW'(is_x_r[k]) >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        if (take) begin
          is_x_r[k+1] <= is_x_r[k] - trial[SW-1:0];
          is_r_r[k+1] <= (is_r_r[k] >> 1) + BIT;
        end else begin
          is_x_r[k+1] <= is_x_r[k];
          is_r_r[k+1] <= is_r_r[k] >> 1;
        end
        is_m_r[k+1]   <= is_m_r[k];
        is_neg_r[k+1] <= is_neg_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        is_val_r[k+1] <= 1'b0;
      end else if (en) begin
        is_val_r[k+1] <= is_val_r[k];
      end
    end
  end

  // restoring divide (mag << 14) / len, one quotient bit per stage
  logic [2:0][NW-1:0] dv_rem_r  [DS];
  logic [2:0][DS-1:0] dv_q_r    [DS];
  logic [MW-1:0]      dv_len_r  [DS];
  logic [2:0]         dv_neg_r  [DS];
  logic               dv_zero_r [DS];
  logic               dv_val_r  [DS];

  for (genvar j = 0; j < DS; j++) begin : g_div
    localparam int SH = DS - 1 - j;
    logic [2:0][NW-1:0] rem_in;
    logic [2:0][DS-1:0] q_in;
    logic [MW-1:0]      len_in;
    logic [2:0]         neg_in;
    logic               zero_in;
    logic               val_in;
    logic [NW-1:0]      dsh;

    if (j == 0) begin : g_first
      always_comb begin
        for (int i = 0; i < 3; i++) rem_in[i] = {is_m_r[IS][i], FB'(0)};
        q_in    = '0;
        len_in  = is_r_r[IS][MW-1:0];
        neg_in  = is_neg_r[IS];
        zero_in = (is_r_r[IS] == '0);
        val_in  = is_val_r[IS];
      end
    end else begin : g_next
      always_comb begin
        rem_in  = dv_rem_r[j-1];
        q_in    = dv_q_r[j-1];
        len_in  = dv_len_r[j-1];
        neg_in  = dv_neg_r[j-1];
        zero_in = dv_zero_r[j-1];
        val_in  = dv_val_r[j-1];
      end
    end

    assign dsh = NW'(len_in) << SH;

    always_ff @(posedge clk) begin
      if (en) begin
        for (int i = 0; i < 3; i++) begin
          if (rem_in[i] >= dsh) begin
            dv_rem_r[j][i] <= rem_in[i] - dsh;
            dv_q_r[j][i]   <= q_in[i] | (DS'(1) << SH);
          end else begin
            dv_rem_r[j][i] <= rem_in[i];
            dv_q_r[j][i]   <= q_in[i];
          end
        end
        dv_len_r[j]  <= len_in;
        dv_neg_r[j]  <= neg_in;
        dv_zero_r[j] <= zero_in;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_val_r[j] <= 1'b0;
      end else if (en) begin
        dv_val_r[j] <= val_in;
      end
    end
  end

  // output: apply sign, zero-length vector gives zero
  logic signed [DW-1:0] od_r [3];
  logic                 od_val_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        if (dv_zero_r[DS-1]) begin
          od_r[i] <= '0;
        end else if (dv_neg_r[DS-1][i]) begin
          od_r[i] <= -DW'(dv_q_r[DS-1][i]);
        end else begin
          od_r[i] <= DW'(dv_q_r[DS-1][i]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n1_val_r    <= 1'b0;
      n2_val_r    <= 1'b0;
      n3_val_r    <= 1'b0;
      is_val_r[0] <= 1'b0;
      od_val_r    <= 1'b0;
    end else if (en) begin
      n1_val_r    <= in_valid;
      n2_val_r    <= n1_val_r;
      n3_val_r    <= n2_val_r;
      is_val_r[0] <= n3_val_r;
      od_val_r    <= dv_val_r[DS-1];
    end
  end

  assign out_valid = od_val_r;
  assign out_dir.x = od_r[0];
  assign out_dir.y = od_r[1];
  assign out_dir.z = od_r[2];

endmodule

// ===== src/point_light_diffuse_specular_shader_unit.sv =====
// Channel  | Signals                          | Moves
// ---------+----------------------------------+------------------------------
// in       | in_valid, in_ready, in_data      | one surface hit per request
// out      | out_valid, out_ready, out_data   | diffuse and specular colors
// cfg      | cfg_we, cfg_idx, cfg_wdata       | light, camera, ratio, color
//
// One request per cycle while no result waits; 4 reflect/setup stages, 52 in
// the normalizers (32 of them the bit-per-stage square root), 3 for dot products,
// 32 for the power chain (one multiply each), 2 for color scaling.
// Sync active-low reset clears all valid bits and config; color resets to FFFFFF.
// A result not taken holds the output register and freezes the whole pipe.
// Depends on plds_pkg and plds_norm.
module point_light_diffuse_specular_shader_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  plds_pkg::in_item_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output plds_pkg::out_item_t                 out_data,
  input  logic                                cfg_we,
  input  logic [plds_pkg::CFG_IDX_W-1:0]      cfg_idx,
  input  logic [plds_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  localparam int VW  = plds_pkg::VEC_W;
  localparam int DW  = plds_pkg::DIR_W;
  localparam int MW  = plds_pkg::MAG_W;
  localparam int PW  = 2 * plds_pkg::MAG_W;
  localparam int QS  = plds_pkg::ONE_SH;
  localparam int PRW = plds_pkg::PROD_W;
  localparam int NL  = plds_pkg::NORM_LAT;
  localparam int SHN = plds_pkg::SHINE_EXPONENT;
  localparam int DSH = plds_pkg::DIF_SH;
  localparam int SSH = plds_pkg::SPEC_SH;

  logic en;
  logic out_valid_r;
  plds_pkg::out_item_t out_data_r;

  assign en        = !out_valid_r || out_ready;
  assign in_ready  = en;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // configuration
  logic signed [31:0] light_r [3];
  logic signed [31:0] cam_r   [3];
  logic [16:0]        ratio_r;
  logic [23:0]        color_r;
  logic [7:0]         ch [3];
  logic [24:0]        cr_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        light_r[i] <= '0;
        cam_r[i]   <= '0;
      end
      ratio_r <= '0;
      color_r <= plds_pkg::COLOR_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        plds_pkg::REG_LIGHT_X:  light_r[0] <= cfg_wdata;
        plds_pkg::REG_LIGHT_Y:  light_r[1] <= cfg_wdata;
        plds_pkg::REG_LIGHT_Z:  light_r[2] <= cfg_wdata;
        plds_pkg::REG_CAMERA_X: cam_r[0]   <= cfg_wdata;
        plds_pkg::REG_CAMERA_Y: cam_r[1]   <= cfg_wdata;
        plds_pkg::REG_CAMERA_Z: cam_r[2]   <= cfg_wdata;
        plds_pkg::REG_RATIO:    ratio_r    <= cfg_wdata[16:0];
        plds_pkg::REG_COLOR:    color_r    <= cfg_wdata[23:0];
      endcase
    end
  end

  assign ch[0] = color_r[23:16];
  assign ch[1] = color_r[15:8];
  assign ch[2] = color_r[7:0];

  // color times ratio, kept static by the user while requests flow; not enforced
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) cr_r[i] <= 25'(ch[i]) * 25'(ratio_r);
  end

  // input unpack
  logic signed [31:0] hit [3];
  logic signed [15:0] nin [3];
  logic signed [15:0] din [3];

  assign hit[0] = in_data.hit_x;
  assign hit[1] = in_data.hit_y;
  assign hit[2] = in_data.hit_z;
  assign nin[0] = in_data.normal_x;
  assign nin[1] = in_data.normal_y;
  assign nin[2] = in_data.normal_z;
  assign din[0] = in_data.incident_x;
  assign din[1] = in_data.incident_y;
  assign din[2] = in_data.incident_z;

  // front end: to-light and to-camera vectors, reflection vector
  logic signed [32:0] f1_vl_r [3], f1_vv_r [3];
  logic signed [15:0] f1_n_r [3], f1_d_r [3];
  logic signed [31:0] f1_ndp_r [3];
  logic signed [32:0] f2_vl_r [3], f2_vv_r [3];
  logic signed [15:0] f2_n_r [3], f2_d_r [3];
  logic signed [33:0] f2_nd_r;
  logic signed [32:0] f3_vl_r [3], f3_vv_r [3];
  logic signed [15:0] f3_n_r [3], f3_d_r [3];
  logic signed [49:0] f3_t_r [3];
  logic signed [VW-1:0] f4_vl_r [3], f4_vv_r [3], f4_vr_r [3];
  logic signed [15:0] f4_n_r [3];
  logic f1_v_r, f2_v_r, f3_v_r, f4_v_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        f1_vl_r[i]  <= 33'(light_r[i]) - 33'(hit[i]);
        f1_vv_r[i]  <= 33'(cam_r[i]) - 33'(hit[i]);
        f1_n_r[i]   <= nin[i];
        f1_d_r[i]   <= din[i];
        f1_ndp_r[i] <= 32'(nin[i]) * 32'(din[i]);

        f2_vl_r[i] <= f1_vl_r[i];
        f2_vv_r[i] <= f1_vv_r[i];
        f2_n_r[i]  <= f1_n_r[i];
        f2_d_r[i]  <= f1_d_r[i];

        f3_t_r[i]  <= 50'(f2_nd_r) * 50'(f2_n_r[i]);
        f3_vl_r[i] <= f2_vl_r[i];
        f3_vv_r[i] <= f2_vv_r[i];
        f3_n_r[i]  <= f2_n_r[i];
        f3_d_r[i]  <= f2_d_r[i];

        // floor(2*nd*n / 2^14) - d * 2^14
        f4_vr_r[i] <= VW'(f3_t_r[i] >>> 13) - (VW'(f3_d_r[i]) <<< 14);
        f4_vl_r[i] <= VW'(f3_vl_r[i]);
        f4_vv_r[i] <= VW'(f3_vv_r[i]);
        f4_n_r[i]  <= f3_n_r[i];
      end
      f2_nd_r <= 34'(f1_ndp_r[0]) + 34'(f1_ndp_r[1]) + 34'(f1_ndp_r[2]);
    end
  end

  // normalizers
  plds_pkg::vec3_t vl_vec, vr_vec, vv_vec;
  plds_pkg::dir3_t l_dir, r_dir, v_dir;
  logic l_val, r_val, v_val;

  assign vl_vec.x = f4_vl_r[0];
  assign vl_vec.y = f4_vl_r[1];
  assign vl_vec.z = f4_vl_r[2];
  assign vr_vec.x = f4_vr_r[0];
  assign vr_vec.y = f4_vr_r[1];
  assign vr_vec.z = f4_vr_r[2];
  assign vv_vec.x = f4_vv_r[0];
  assign vv_vec.y = f4_vv_r[1];
  assign vv_vec.z = f4_vv_r[2];

  plds_norm u_norm_l (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(f4_v_r), .in_vec(vl_vec),
    .out_valid(l_val), .out_dir(l_dir)
  );

  plds_norm u_norm_r (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(f4_v_r), .in_vec(vr_vec),
    .out_valid(r_val), .out_dir(r_dir)
  );

  plds_norm u_norm_v (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(f4_v_r), .in_vec(vv_vec),
    .out_valid(v_val), .out_dir(v_dir)
  );

  // normal rides alongside the normalizers
  logic signed [15:0] nl_r [NL][3];

  always_ff @(posedge clk) begin
    if (en) begin
      nl_r[0] <= f4_n_r;
      for (int k = 1; k < NL; k++) nl_r[k] <= nl_r[k-1];
    end
  end

  logic signed [DW-1:0] ld [3], rd [3], vd [3];

  assign ld[0] = l_dir.x;
  assign ld[1] = l_dir.y;
  assign ld[2] = l_dir.z;
  assign rd[0] = r_dir.x;
  assign rd[1] = r_dir.y;
  assign rd[2] = r_dir.z;
  assign vd[0] = v_dir.x;
  assign vd[1] = v_dir.y;
  assign vd[2] = v_dir.z;

  // dot products and diffuse scaling
  logic signed [31:0] b1_nl_r [3], b1_rv_r [3];
  logic signed [33:0] b2_ndl_r, b2_rv_r;
  logic [PRW-1:0]     b3_dp_r [3];
  logic [MW-1:0]      b3_p_r;
  logic b1_v_r, b2_v_r, b3_v_r;
  logic               ndl_pos, rv_pos;
  logic [33:0]        rv4;
  logic [MW-1:0]      p_nxt;

  assign ndl_pos = !b2_ndl_r[33] && (b2_ndl_r != '0);
  assign rv_pos  = !b2_rv_r[33] && (b2_rv_r != '0);
  assign rv4     = {b2_rv_r[31:0], 2'b00};

  always_comb begin
    if (!rv_pos) begin
      p_nxt = '0;   // zero power term gives zero specular
    end else if (rv4 > 34'(plds_pkg::ONE_Q30)) begin
      p_nxt = plds_pkg::ONE_Q30;
    end else begin
      p_nxt = rv4[MW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        b1_nl_r[i] <= 32'(nl_r[NL-1][i]) * 32'(ld[i]);
        b1_rv_r[i] <= 32'(rd[i]) * 32'(vd[i]);
        b3_dp_r[i] <= ndl_pos ? PRW'(cr_r[i]) * PRW'(b2_ndl_r[30:0]) : '0;
      end
      b2_ndl_r <= 34'(b1_nl_r[0]) + 34'(b1_nl_r[1]) + 34'(b1_nl_r[2]);
      b2_rv_r  <= 34'(b1_rv_r[0]) + 34'(b1_rv_r[1]) + 34'(b1_rv_r[2]);
      b3_p_r   <= p_nxt;
    end
  end

  logic [2:0][15:0] b3_dsat;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      b3_dsat[i] = (|b3_dp_r[i][PRW-1:DSH+16]) ? 16'hFFFF : b3_dp_r[i][DSH+15:DSH];
    end
  end

  // power chain: acc = floor(acc * p / 2^30), one multiply per stage
  logic [MW-1:0]    pw_acc_r [SHN];
  logic [MW-1:0]    pw_p_r   [SHN];
  logic [2:0][15:0] pw_d_r   [SHN];
  logic             pw_v_r   [SHN];

  for (genvar k = 0; k < SHN; k++) begin : g_pow
    logic [MW-1:0]    acc_in, p_in;
    logic [2:0][15:0] d_in;
    logic             v_in;
    logic [PW-1:0]    prod;

    if (k == 0) begin : g_first
      assign acc_in = plds_pkg::ONE_Q30;
      assign p_in   = b3_p_r;
      assign d_in   = b3_dsat;
      assign v_in   = b3_v_r;
    end else begin : g_next
      assign acc_in = pw_acc_r[k-1];
      assign p_in   = pw_p_r[k-1];
      assign d_in   = pw_d_r[k-1];
      assign v_in   = pw_v_r[k-1];
    end

    assign prod = PW'(acc_in) * PW'(p_in);

    always_ff @(posedge clk) begin
      if (en) begin
        pw_acc_r[k] <= prod[QS+MW-1:QS];
        pw_p_r[k]   <= p_in;
        pw_d_r[k]   <= d_in;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        pw_v_r[k] <= 1'b0;
      end else if (en) begin
        pw_v_r[k] <= v_in;
      end
    end
  end

  // specular scaling and output register
  logic [PRW-1:0]   c1_sp_r [3];
  logic [2:0][15:0] c1_d_r;
  logic             c1_v_r;
  logic [2:0][15:0] ssat;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ssat[i] = (|c1_sp_r[i][PRW-1:SSH+16]) ? 16'hFFFF : c1_sp_r[i][SSH+15:SSH];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        c1_sp_r[i] <= PRW'(cr_r[i]) * PRW'(pw_acc_r[SHN-1]);
      end
      c1_d_r <= pw_d_r[SHN-1];
      out_data_r.diffuse_red    <= c1_d_r[0];
      out_data_r.diffuse_green  <= c1_d_r[1];
      out_data_r.diffuse_blue   <= c1_d_r[2];
      out_data_r.specular_red   <= ssat[0];
      out_data_r.specular_green <= ssat[1];
      out_data_r.specular_blue  <= ssat[2];
    end
  end

  // valid chain outside the normalizers and the power stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_v_r      <= 1'b0;
      f2_v_r      <= 1'b0;
      f3_v_r      <= 1'b0;
      f4_v_r      <= 1'b0;
      b1_v_r      <= 1'b0;
      b2_v_r      <= 1'b0;
      b3_v_r      <= 1'b0;
      c1_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      f1_v_r      <= in_valid;
      f2_v_r      <= f1_v_r;
      f3_v_r      <= f2_v_r;
      f4_v_r      <= f3_v_r;
      b1_v_r      <= l_val && r_val && v_val;
      b2_v_r      <= b1_v_r;
      b3_v_r      <= b2_v_r;
      c1_v_r      <= pw_v_r[SHN-1];
      out_valid_r <= c1_v_r;
    end
  end

endmodule

// ===== src/plds_chk.sv =====
// Port-level checker for the point light shader unit, bound to the top level.
// Depends on plds_pkg and the assertion macro header.
`include "point_light_diffuse_specular_shader_unit_assert.svh"

module plds_chk (
  input logic                clk,
  input logic                rst_n,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input plds_pkg::out_item_t out_data
);

  // a result that waits keeps its value
  `PLDS_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))

  // a waiting result freezes the pipe, so no new request is taken
  `PLDS_ASSERT_IMP(a_stall_blocks_in, out_valid && !out_ready, !in_ready)

  // with the output register empty the pipe always moves
  `PLDS_ASSERT_IMP(a_empty_takes_in, !out_valid, in_ready)

  // reset flushes the pipe
  `PLDS_ASSERT_RST(a_rst_clears, !rst_n, !out_valid)

endmodule

bind point_light_diffuse_specular_shader_unit plds_chk u_plds_chk (
  .clk(clk),
  .rst_n(rst_n),
  .in_ready(in_ready),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_data(out_data)
);
